>>> rtl/core/klte_pkg.sv
// Shared widths, operation and status codes, and sequencer states of the keyed list table.
`default_nettype none

package klte_pkg;

	localparam int KEY_W            = 32;
	localparam int FUNC_W           = 3;
	localparam int STATUS_W         = 2;
	localparam int POS_W            = 4;
	localparam int COUNT_W          = 5;
	localparam int CAPACITY_DEFAULT = 16;

	localparam logic [FUNC_W-1:0] FUNC_INSERT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_SEARCH = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_MAX    = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_MIN    = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_SUCC   = 3'd5;
	localparam logic [FUNC_W-1:0] FUNC_PRED   = 3'd6;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOMATCH = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SHIFT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

>>> rtl/core/klte_req_if.sv
// Request channel: operation code and key.
`default_nettype none

interface klte_req_if;
	logic                                valid;
	logic                                ready;
	logic        [klte_pkg::FUNC_W-1:0] func;
	logic signed [klte_pkg::KEY_W-1:0]  key_value;

	modport source (output valid, output func, output key_value, input ready);
	modport sink   (input valid, input func, input key_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/klte_rsp_if.sv
// Response channel: status, key, position and entry count.
`default_nettype none

interface klte_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic        [klte_pkg::STATUS_W-1:0] status;
	logic signed [klte_pkg::KEY_W-1:0]    result_key;
	logic        [klte_pkg::POS_W-1:0]    position;
	logic        [klte_pkg::COUNT_W-1:0]  entry_count;

	modport source (output valid, output status, output result_key, output position,
		output entry_count, input ready);
	modport sink   (input valid, input status, input result_key, input position,
		input entry_count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/klte_cmp.sv
// Shared key comparator: decides whether a scanned entry replaces the current best.
`default_nettype none

module klte_cmp (
	input  wire logic        [klte_pkg::FUNC_W-1:0] func,
	input  wire logic signed [klte_pkg::KEY_W-1:0]  key_value,
	input  wire logic signed [klte_pkg::KEY_W-1:0]  entry,
	input  wire logic signed [klte_pkg::KEY_W-1:0]  best,
	input  wire logic                               found,
	output logic                                    take
);

	logic above_key;
	logic below_key;
	logic above_best;
	logic below_best;

	assign above_key  = entry > key_value;
	assign below_key  = entry < key_value;
	assign above_best = entry > best;
	assign below_best = entry < best;

	always_comb begin
		case (func)
			klte_pkg::FUNC_SEARCH,
			klte_pkg::FUNC_DELETE: take = !found && (entry == key_value);
			klte_pkg::FUNC_MAX:    take = !found || above_best;
			klte_pkg::FUNC_MIN:    take = !found || below_best;
			klte_pkg::FUNC_SUCC:   take = above_key && (!found || below_best);
			klte_pkg::FUNC_PRED:   take = below_key && (!found || above_best);
			default:               take = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/keyed_list_table_engine_core.sv
// Top level of the keyed list table: entry memory, scan sequencer and response register.
//
// Channel | Dir | Payload                                      | Transaction
// req     | in  | func, key_value                              | valid & ready
// rsp     | out | status, result_key, position, entry_count    | valid & ready
//
// Insert, an empty table and an unused code: response valid once dispatch moves straight to done.
// Other operations scan the held entries, one entry read per cycle from the single read port
// and judged by the one shared comparator. A delete that hits then reads each entry after the
// removed one and writes it one place lower to close the gap.
// The response holds until taken, and the next request can be accepted in the cycle after.
// Reset empties the table at once; no clearing pass is needed.
`default_nettype none

module keyed_list_table_engine_core #(
	parameter int CAPACITY = klte_pkg::CAPACITY_DEFAULT
) (
	input wire logic clk,
	input wire logic arst_n,
	klte_req_if.sink   req,
	klte_rsp_if.source rsp
);

	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int KEY_W   = klte_pkg::KEY_W;
	localparam int POS_W   = klte_pkg::POS_W;
	localparam int COUNT_W = klte_pkg::COUNT_W;

	klte_pkg::state_t state_q;
	klte_pkg::state_t state_d;

	logic        [klte_pkg::FUNC_W-1:0]   func_q;
	logic signed [KEY_W-1:0]              key_q;
	logic        [CNT_W-1:0]              count_q;
	logic        [CNT_W-1:0]              rd_q;
	logic                                 vld_s1;
	logic        [IDX_W-1:0]              idx_s1;
	logic signed [KEY_W-1:0]              rdata_s1;
	logic                                 found_q;
	logic        [IDX_W-1:0]              best_idx_q;
	logic signed [KEY_W-1:0]              best_key_q;
	logic        [klte_pkg::STATUS_W-1:0] status_q;
	logic signed [KEY_W-1:0]              rkey_q;
	logic        [IDX_W-1:0]              pos_q;

	logic [KEY_W-1:0] mem [CAPACITY];

	logic                    walking;
	logic                    rd_en;
	logic                    walk_end;
	logic                    table_full;
	logic                    func_unused;
	logic                    take;
	logic                    mem_we;
	logic [IDX_W-1:0]        mem_waddr;
	logic [KEY_W-1:0]        mem_wdata;

	assign table_full  = count_q >= CNT_W'(CAPACITY);
	assign func_unused = func_q > klte_pkg::FUNC_PRED;
	assign walk_end    = (rd_q == count_q) && !vld_s1;

	klte_cmp u_cmp (
		.func      (func_q),
		.key_value (key_q),
		.entry     (rdata_s1),
		.best      (best_key_q),
		.found     (found_q),
		.take      (take)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			klte_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = klte_pkg::ST_DISPATCH;
				end
			end
			klte_pkg::ST_DISPATCH: begin
				if (func_q == klte_pkg::FUNC_INSERT || func_unused || count_q == '0) begin
					state_d = klte_pkg::ST_DONE;
				end else begin
					state_d = klte_pkg::ST_SCAN;
				end
			end
			klte_pkg::ST_SCAN: begin
				if (walk_end) begin
					if (found_q && func_q == klte_pkg::FUNC_DELETE) begin
						state_d = klte_pkg::ST_SHIFT;
					end else begin
						state_d = klte_pkg::ST_DONE;
					end
				end
			end
			klte_pkg::ST_SHIFT: begin
				if (walk_end) begin
					state_d = klte_pkg::ST_DONE;
				end
			end
			klte_pkg::ST_DONE: begin
				if (rsp.ready) begin
					state_d = klte_pkg::ST_IDLE;
				end
			end
			default: state_d = klte_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		walking   = (state_q == klte_pkg::ST_SCAN) || (state_q == klte_pkg::ST_SHIFT);
		rd_en     = walking && (rd_q != count_q);
		req.ready = state_q == klte_pkg::ST_IDLE;
		rsp.valid = state_q == klte_pkg::ST_DONE;
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = key_q;
		case (state_q)
			klte_pkg::ST_DISPATCH: begin
				mem_we = (func_q == klte_pkg::FUNC_INSERT) && !table_full;
			end
			klte_pkg::ST_SHIFT: begin
				// Each entry read at index i is written back one place lower.
				mem_we    = vld_s1;
				mem_waddr = idx_s1 - 1'b1;
				mem_wdata = rdata_s1;
			end
			default: mem_we = 1'b0;
		endcase
	end

	assign rsp.status      = status_q;
	assign rsp.result_key  = rkey_q;
	assign rsp.position    = POS_W'(pos_q);
	assign rsp.entry_count = COUNT_W'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= klte_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers: fill count, read pointer, read pipeline valid and the found flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= rd_en;
			if (rd_en) begin
				rd_q <= rd_q + 1'b1;
			end
			case (state_q)
				klte_pkg::ST_DISPATCH: begin
					rd_q    <= '0;
					found_q <= 1'b0;
					if (func_q == klte_pkg::FUNC_INSERT && !table_full) begin
						count_q <= count_q + 1'b1;
					end
				end
				klte_pkg::ST_SCAN: begin
					if (vld_s1 && take) begin
						found_q <= 1'b1;
					end
					if (walk_end) begin
						rd_q <= CNT_W'(best_idx_q) + 1'b1;
					end
				end
				klte_pkg::ST_SHIFT: begin
					if (walk_end) begin
						count_q <= count_q - 1'b1;
					end
				end
				default: found_q <= found_q;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q[IDX_W-1:0];
		if (req.valid && req.ready) begin
			func_q <= req.func;
			key_q  <= req.key_value;
		end
		case (state_q)
			klte_pkg::ST_DISPATCH: begin
				best_idx_q <= '0;
				best_key_q <= '0;
				rkey_q     <= '0;
				pos_q      <= '0;
				if (func_q == klte_pkg::FUNC_INSERT) begin
					if (table_full) begin
						status_q <= klte_pkg::STATUS_FULL;
					end else begin
						status_q <= klte_pkg::STATUS_OK;
						rkey_q   <= key_q;
						pos_q    <= count_q[IDX_W-1:0];
					end
				end else if (func_unused) begin
					status_q <= klte_pkg::STATUS_NOMATCH;
				end else begin
					status_q <= klte_pkg::STATUS_EMPTY;
				end
			end
			klte_pkg::ST_SCAN: begin
				if (vld_s1 && take) begin
					best_idx_q <= idx_s1;
					best_key_q <= rdata_s1;
				end
				if (walk_end) begin
					if (found_q) begin
						status_q <= klte_pkg::STATUS_OK;
						rkey_q   <= best_key_q;
						pos_q    <= best_idx_q;
					end else begin
						status_q <= klte_pkg::STATUS_NOMATCH;
						rkey_q   <= '0;
						pos_q    <= '0;
					end
				end
			end
			default: status_q <= status_q;
		endcase
	end

	// Entry memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_q[IDX_W-1:0]];
		end
	end

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("Entry count exceeds the table capacity.");

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == klte_pkg::ST_DISPATCH))
		else $error("Accepted transaction was not dispatched.");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (rd_q < count_q))
		else $error("Read beyond the held entries.");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && status_q == klte_pkg::STATUS_FULL) |-> table_full)
		else $error("Full status reported with room left in the table.");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == klte_pkg::ST_SHIFT && vld_s1) |-> (idx_s1 != '0))
		else $error("Close-up write would fall below the first entry.");
`endif

endmodule

`default_nettype wire
